### sv/cpc_pkg.sv
// cpc_pkg: widths, constants and sequencer state type for the circular prime checker
// no dependencies; imported by the channel interfaces and the top level
`timescale 1ns / 1ps

package cpc_pkg;

   // field widths of the channel beats
   localparam int NUMBER_W = 20;
   localparam int RESULT_W = 1;

   // working widths: a 20-bit number has at most 7 decimal digits, so every
   // rotation stays below 10**7 < 2**24
   localparam int VAL_W = 24;
   // trial divisors stay below sqrt(10**7) + 2 < 2**12
   localparam int DIV_W = 12;
   localparam int SQ_W  = 25;
   localparam int DIG_W = 4;
   localparam int STEP_W = 5;
   localparam int LEAD_W = 4;

   localparam int TEN = 10;
   localparam int FIRST_DIVISOR = 2;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_COUNT  = 7'b0000010,
      ST_PRIME  = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_DIVIDE = 7'b0010000,
      ST_ROTATE = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

endpackage

### sv/cpc_if.sv
// cpc_if: valid/ready channel interfaces for request and response beats
// depends on cpc_pkg for the field widths
`timescale 1ns / 1ps

interface cpc_req_bus
   import cpc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [NUMBER_W-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface cpc_rsp_bus
   import cpc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [RESULT_W-1:0] is_circular_prime;

   modport source (output valid, output is_circular_prime, input ready);
   modport sink   (input valid, input is_circular_prime, output ready);
endinterface

### sv/circular_prime_check.sv
// circular_prime_check: decides whether every decimal rotation of a number is prime
// depends on cpc_pkg and the channel interfaces in cpc_if.sv
//
//   channel   dir   beat payload               handshake
//   req_ch    in    number [19:0]               valid/ready, taken while idle
//   rsp_ch    out   is_circular_prime [0:0]     valid/ready, held until taken
//
// one number at a time; req_ch.ready is high only while no number is in work
// per number: accept, count the digits, then per rotation test divisor 2 and
//   the odd ones up to sqrt of the rotation, each by a 24-step radix-2
//   restoring remainder loop, and peel the leading digit to form the next
//   rotation
// reset is synchronous and returns the sequencer to idle; no clearing pass
// a stalled response holds its beat and keeps req_ch.ready low
`timescale 1ns / 1ps

module circular_prime_check
   import cpc_pkg::*;
#(
   parameter int MAX_DIGITS = 6
) (
   input  logic       clock,
   input  logic       reset,
   cpc_req_bus.sink   req_ch,
   cpc_rsp_bus.source rsp_ch
);

   // sequencer and working registers
   state_type             state_ff, state_in;
   logic [VAL_W-1:0]      val_ff, val_in;       // number under test
   logic [VAL_W-1:0]      top_ff, top_in;       // 10**(digits-1)
   logic [DIG_W-1:0]      digits_ff, digits_in;
   logic [DIG_W-1:0]      rot_ff, rot_in;       // rotations already proven prime
   logic [VAL_W-1:0]      cur_ff, cur_in;       // current rotation
   logic [DIV_W-1:0]      div_ff, div_in;       // trial divisor
   logic [SQ_W-1:0]       sq_ff, sq_in;         // divisor squared
   logic [VAL_W-1:0]      dvd_ff, dvd_in;       // dividend shift register
   logic [DIV_W-1:0]      rem_ff, rem_in;       // partial remainder
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [VAL_W-1:0]      rest_ff, rest_in;     // rotation minus leading digit
   logic [LEAD_W-1:0]     lead_ff, lead_in;     // leading digit
   logic [RESULT_W-1:0]   res_ff, res_in;

   // shared datapath terms
   logic [VAL_W+3:0]      top_x10;
   logic [VAL_W+3:0]      rot_next;
   logic [DIV_W:0]        rem_try;
   logic [DIV_W-1:0]      rem_step;
   logic                  last_step;

   assign top_x10  = {1'b0, top_ff, 3'b000} + {3'b000, top_ff, 1'b0};
   assign rot_next = {1'b0, rest_ff, 3'b000} + {3'b000, rest_ff, 1'b0}
                   + {{VAL_W{1'b0}}, lead_ff};

   // one restoring step of v % d
   assign rem_try   = {rem_ff, dvd_ff[VAL_W-1]};
   assign rem_step  = (rem_try >= {1'b0, div_ff}) ? DIV_W'(rem_try - {1'b0, div_ff})
                                                   : rem_try[DIV_W-1:0];
   assign last_step = (step_ff == STEP_W'(VAL_W - 1));

   always_comb begin
      state_in  = state_ff;
      val_in    = val_ff;
      top_in    = top_ff;
      digits_in = digits_ff;
      rot_in    = rot_ff;
      cur_in    = cur_ff;
      div_in    = div_ff;
      sq_in     = sq_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      rest_in   = rest_ff;
      lead_in   = lead_ff;
      res_in    = res_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               val_in    = VAL_W'(req_ch.number);
               top_in    = VAL_W'(1);
               digits_in = DIG_W'(1);
               // zero has no digits and is not prime
               if (req_ch.number == '0) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_COUNT;
               end
            end
         end

         ST_COUNT: begin
            // grow top by ten while it still fits under the number
            if (top_x10 <= {4'b0000, val_ff}) begin
               top_in    = top_x10[VAL_W-1:0];
               digits_in = digits_ff + DIG_W'(1);
            end else if (digits_ff > DIG_W'(MAX_DIGITS)) begin
               res_in   = '0;
               state_in = ST_DONE;
            end else begin
               cur_in   = val_ff;
               rot_in   = '0;
               state_in = ST_PRIME;
            end
         end

         ST_PRIME: begin
            if (cur_ff < VAL_W'(FIRST_DIVISOR)) begin
               res_in   = '0;
               state_in = ST_DONE;
            end else begin
               div_in   = DIV_W'(FIRST_DIVISOR);
               sq_in    = SQ_W'(FIRST_DIVISOR * FIRST_DIVISOR);
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (sq_ff > {1'b0, cur_ff}) begin
               // no divisor found: this rotation is prime
               if (rot_ff == digits_ff - DIG_W'(1)) begin
                  res_in   = RESULT_W'(1);
                  state_in = ST_DONE;
               end else begin
                  rot_in   = rot_ff + DIG_W'(1);
                  rest_in  = cur_ff;
                  lead_in  = '0;
                  state_in = ST_ROTATE;
               end
            end else begin
               dvd_in   = cur_ff;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIVIDE;
            end
         end

         ST_DIVIDE: begin
            rem_in  = rem_step;
            dvd_in  = {dvd_ff[VAL_W-2:0], 1'b0};
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               if (rem_step == '0) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  // after two, only odd divisors can find a new factor
                  if (div_ff == DIV_W'(FIRST_DIVISOR)) begin
                     div_in = DIV_W'(FIRST_DIVISOR + 1);
                     sq_in  = SQ_W'((FIRST_DIVISOR + 1) * (FIRST_DIVISOR + 1));
                  end else begin
                     div_in = div_ff + DIV_W'(2);
                     sq_in  = sq_ff + {{(SQ_W-DIV_W-2){1'b0}}, div_ff, 2'b00} + SQ_W'(4);
                  end
                  state_in = ST_CHECK;
               end
            end
         end

         ST_ROTATE: begin
            // peel the leading digit by repeated subtraction of top
            if (rest_ff >= top_ff) begin
               rest_in = rest_ff - top_ff;
               lead_in = lead_ff + LEAD_W'(1);
            end else begin
               cur_in   = rot_next[VAL_W-1:0];
               state_in = ST_PRIME;
            end
         end

         ST_DONE: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      top_ff    <= top_in;
      digits_ff <= digits_in;
      rot_ff    <= rot_in;
      cur_ff    <= cur_in;
      div_ff    <= div_in;
      sq_ff     <= sq_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      rest_ff   <= rest_in;
      lead_ff   <= lead_in;
      res_ff    <= res_in;
   end

   assign req_ch.ready             = (state_ff == ST_IDLE);
   assign rsp_ch.valid             = (state_ff == ST_DONE);
   assign rsp_ch.is_circular_prime = res_ff;

   // partial remainder always stays below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

   // the running square tracks the divisor
   a_sq_tracks_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (sq_ff == SQ_W'(div_ff) * SQ_W'(div_ff)))
      else $error("divisor square out of step");

   // an accepted beat starts a count or answers at once
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_COUNT || state_ff == ST_DONE))
      else $error("bad state after request beat");

   // leading digit is a decimal digit
   a_lead_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROTATE) |-> (lead_ff <= LEAD_W'(9)))
      else $error("leading digit out of range");

endmodule
